@@ rtl/tnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared constants and types of the triangle normal and centroid block.
// ----------------------------------------------------------------------------
package tnc_pkg;

    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int COORD_BITS_DEF   = 16;
    localparam int INDEX_BITS       = 12;
    localparam int FIELD_BITS       = 16;
    localparam int NORM_ONE         = 16384;
    localparam int QUO_BITS         = 31;
    localparam int ROOT_STEPS       = 16;

    // command codes carried on s_tuser
    localparam logic FN_WRITE = 1'b0;
    localparam logic FN_FACE  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } norm_stat_t;

endpackage

@@ rtl/tnc_vstore.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_vstore
// Single-port vertex memory with registered read.
// ----------------------------------------------------------------------------
module tnc_vstore #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/tnc_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_norm
// Serial normalizer: squares, long division and integer square root give
// round(16384 * n / |n|) for each cross product component.
// ----------------------------------------------------------------------------
module tnc_norm #(
    parameter int COORD_BITS = tnc_pkg::COORD_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic signed [2*COORD_BITS+2:0]            n_x,
    input  logic signed [2*COORD_BITS+2:0]            n_y,
    input  logic signed [2*COORD_BITS+2:0]            n_z,
    output tnc_pkg::norm_stat_t                       stat,
    output logic signed [tnc_pkg::FIELD_BITS-1:0]     q_x,
    output logic signed [tnc_pkg::FIELD_BITS-1:0]     q_y,
    output logic signed [tnc_pkg::FIELD_BITS-1:0]     q_z
);
    import tnc_pkg::*;

    localparam int NW  = 2*COORD_BITS + 3;
    localparam int MW  = NW - 1;
    localparam int QW  = 2*MW;
    localparam int SW  = QW + 2;
    localparam int CTW = $clog2(((MW > QUO_BITS) ? MW : QUO_BITS) + 1);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SQ   = 3'd1;
    localparam logic [2:0] P_SUM  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_ROOT = 3'd4;

    logic [2:0]     phase_reg, phase_next;
    logic [1:0]     comp_reg, comp_next;
    logic [CTW-1:0] cnt_reg, cnt_next;
    logic           done_reg, done_next;

    logic [MW-1:0]  mag_reg [0:2];
    logic           neg_reg [0:2];
    logic [QW-1:0]  sq_reg [0:2];
    logic [QW-1:0]  mcand_reg;
    logic [MW-1:0]  mplier_reg;
    logic [SW-1:0]  sum_reg;
    logic [SW:0]    rem_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [31:0]    op_reg, res_reg, bit_reg;
    logic signed [FIELD_BITS-1:0] q_reg [0:2];

    logic [SW:0]    div_t;
    logic           div_ge;
    logic [QUO_BITS-1:0] quo_next;
    logic [31:0]    root_sum, res_next;
    logic           root_ge;
    logic [FIELD_BITS-1:0] q_mag;

    function automatic logic [MW-1:0] abs_n(input logic signed [NW-1:0] v);
        logic [NW-1:0] a;
        a = v[NW-1] ? NW'(-v) : NW'(v);
        return a[MW-1:0];
    endfunction

    always_comb begin
        div_t    = (cnt_reg == '0) ? (SW+1)'(sq_reg[comp_reg]) : (rem_reg << 1);
        div_ge   = (div_t >= {1'b0, sum_reg});
        quo_next = {quo_reg[QUO_BITS-2:0], div_ge};
        root_sum = res_reg + bit_reg;
        root_ge  = (op_reg >= root_sum);
        res_next = root_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        q_mag    = FIELD_BITS'((res_next + 32'd1) >> 1);
    end

    always_comb begin
        phase_next = phase_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (phase_reg)
            P_IDLE: begin
                if (start) begin
                    phase_next = P_SQ;
                    comp_next  = 2'd0;
                    cnt_next   = '0;
                end
            end
            P_SQ: begin
                if (cnt_reg == CTW'(MW)) begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2) begin
                        phase_next = P_SUM;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            P_SUM: begin
                phase_next = P_DIV;
                comp_next  = 2'd0;
                cnt_next   = '0;
            end
            P_DIV: begin
                if (cnt_reg == CTW'(QUO_BITS - 1)) begin
                    phase_next = P_ROOT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            P_ROOT: begin
                if (cnt_reg == CTW'(ROOT_STEPS - 1)) begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2) begin
                        phase_next = P_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        phase_next = P_DIV;
                        comp_next  = comp_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            comp_reg  <= 2'd0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            P_IDLE: begin
                if (start) begin
                    mag_reg[0] <= abs_n(n_x);
                    mag_reg[1] <= abs_n(n_y);
                    mag_reg[2] <= abs_n(n_z);
                    neg_reg[0] <= n_x[NW-1];
                    neg_reg[1] <= n_y[NW-1];
                    neg_reg[2] <= n_z[NW-1];
                end
            end
            P_SQ: begin
                if (cnt_reg == '0) begin
                    mcand_reg        <= QW'(mag_reg[comp_reg]);
                    mplier_reg       <= mag_reg[comp_reg];
                    sq_reg[comp_reg] <= '0;
                end else begin
                    if (mplier_reg[0]) begin
                        sq_reg[comp_reg] <= sq_reg[comp_reg] + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            P_SUM: begin
                sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            end
            P_DIV: begin
                rem_reg <= div_ge ? (div_t - {1'b0, sum_reg}) : div_t;
                quo_reg <= quo_next;
                if (cnt_reg == CTW'(QUO_BITS - 1)) begin
                    op_reg  <= 32'(quo_next);
                    res_reg <= '0;
                    bit_reg <= 32'h4000_0000;
                end
            end
            P_ROOT: begin
                if (root_ge) begin
                    op_reg <= op_reg - root_sum;
                end
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == CTW'(ROOT_STEPS - 1)) begin
                    q_reg[comp_reg] <= neg_reg[comp_reg] ? -$signed(q_mag) : $signed(q_mag);
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.busy = (phase_reg != P_IDLE);
    assign stat.done = done_reg;
    assign q_x = q_reg[0];
    assign q_y = q_reg[1];
    assign q_z = q_reg[2];

endmodule

@@ rtl/triangle_normal_centroid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_centroid
// Vertex store with face unit normal (Q1.14) and centroid computation.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one word per command. s_tuser = 0 writes vertex corner_a with
//   pos_x/y/z; s_tuser = 1 asks for the face corner_a, corner_b, corner_c.
//   m_ channel: one word per face; nothing is returned for a vertex write.
// sequence
//   a vertex write goes straight to memory. a face runs corner reads on the
//   single memory port, nine steps of one shared multiplier (cross product
//   and centroid), then the serial normalizer, which runs a shift-add square,
//   a 31-step long division and a 16-step square root for each component.
//   a degenerate face skips the normalizer.
// stalls
//   the result sits in an output register; the next command is taken while
//   it waits, and a new result is held back until m_tready frees it.
// reset
//   aresetn clears control only; vertex memory is undefined until written.
// ----------------------------------------------------------------------------
module triangle_normal_centroid #(
    parameter int VERTEX_COUNT = tnc_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = tnc_pkg::COORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // corner_a, corner_b, corner_c, pos_x, pos_y, pos_z, zero pad
    input  logic [87:0] s_tdata,
    // func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // norm_x, norm_y, norm_z, mid_x, mid_y, mid_z
    output logic [95:0] m_tdata,
    // degenerate
    output logic        m_tuser
);
    import tnc_pkg::*;

    localparam int AW  = $clog2(VERTEX_COUNT);
    localparam int CW  = COORD_BITS;
    localparam int NW  = 2*CW + 3;
    localparam int OW  = CW + 4;
    localparam int MS  = INDEX_BITS + AW;
    localparam int MR  = ((1 << MS) + VERTEX_COUNT - 1) / VERTEX_COUNT;
    localparam int D3S = CW + 3;
    localparam int D3R = ((1 << D3S) + 2) / 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EDGE = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_NORM = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_tvalid_reg, m_tvalid_next;

    logic [INDEX_BITS-1:0] corner_reg [0:2];
    logic signed [CW-1:0]  p_reg [0:2][0:2];
    logic signed [CW:0]    e1_reg [0:2];
    logic signed [CW:0]    e2_reg [0:2];
    logic [CW:0]           x_reg [0:2];
    logic                  sneg_reg [0:2];
    logic signed [NW-1:0]  t_reg;
    logic signed [NW-1:0]  n_reg [0:2];
    logic signed [CW+1:0]  mid_reg [0:2];
    logic                  deg_reg;
    logic [95:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    logic                  accept, out_load, norm_start;
    logic [INDEX_BITS-1:0] raw_index;
    logic [AW-1:0]         mem_addr;
    logic                  mem_we;
    logic [3*CW-1:0]       mem_wdata, mem_rdata;
    logic signed [OW-1:0]  mul_a, mul_b;
    logic signed [2*OW-1:0] mul_p;
    logic [CW:0]           d3_q;
    logic signed [CW+1:0]  sum_s [0:2];
    logic                  n_zero;
    norm_stat_t            nstat;
    logic signed [FIELD_BITS-1:0] q_x, q_y, q_z;

    function automatic logic [AW-1:0] wrap_index(input logic [INDEX_BITS-1:0] f);
        logic [63:0] q;
        logic [63:0] r;
        q = (64'(f) * 64'(MR)) >> MS;
        r = 64'(f) - q * 64'(VERTEX_COUNT);
        if (r >= 64'(VERTEX_COUNT)) begin
            r = r - 64'(VERTEX_COUNT);
        end
        return r[AW-1:0];
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        raw_index = s_tdata[11:0];
        if (state_reg == S_READ) begin
            case (cnt_reg)
                4'd0:    raw_index = corner_reg[0];
                4'd1:    raw_index = corner_reg[1];
                default: raw_index = corner_reg[2];
            endcase
        end
    end

    assign mem_addr  = wrap_index(raw_index);
    assign mem_we    = accept && (s_tuser == FN_WRITE);
    assign mem_wdata = {CW'(s_tdata[83:68]), CW'(s_tdata[67:52]), CW'(s_tdata[51:36])};

    tnc_vstore #(
        .DEPTH (VERTEX_COUNT),
        .AW    (AW),
        .DW    (3*CW)
    ) u_vstore (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // shared multiplier: cross product terms, then divide by three
    always_comb begin
        case (cnt_reg)
            4'd0: begin mul_a = OW'(e1_reg[1]); mul_b = OW'(e2_reg[2]); end
            4'd1: begin mul_a = OW'(e1_reg[2]); mul_b = OW'(e2_reg[1]); end
            4'd2: begin mul_a = OW'(e1_reg[2]); mul_b = OW'(e2_reg[0]); end
            4'd3: begin mul_a = OW'(e1_reg[0]); mul_b = OW'(e2_reg[2]); end
            4'd4: begin mul_a = OW'(e1_reg[0]); mul_b = OW'(e2_reg[1]); end
            4'd5: begin mul_a = OW'(e1_reg[1]); mul_b = OW'(e2_reg[0]); end
            4'd6: begin mul_a = $signed(OW'(x_reg[0])); mul_b = OW'(D3R); end
            4'd7: begin mul_a = $signed(OW'(x_reg[1])); mul_b = OW'(D3R); end
            default: begin mul_a = $signed(OW'(x_reg[2])); mul_b = OW'(D3R); end
        endcase
        mul_p = mul_a * mul_b;
        d3_q  = mul_p[D3S +: CW+1];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_s[i] = (CW+2)'(p_reg[0][i]) + (CW+2)'(p_reg[1][i]) + (CW+2)'(p_reg[2][i]);
        end
    end

    assign n_zero     = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
    assign norm_start = (state_reg == S_MUL) && (cnt_reg == 4'd8) && !n_zero;
    assign out_load   = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    tnc_norm #(
        .COORD_BITS (COORD_BITS)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .n_x     (n_reg[0]),
        .n_y     (n_reg[1]),
        .n_z     (n_reg[2]),
        .stat    (nstat),
        .q_x     (q_x),
        .q_y     (q_y),
        .q_z     (q_z)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept && (s_tuser == FN_FACE)) begin
                    state_next = S_READ;
                    cnt_next   = 4'd0;
                end
            end
            S_READ: begin
                if (cnt_reg == 4'd3) begin
                    state_next = S_EDGE;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_EDGE: begin
                state_next = S_MUL;
                cnt_next   = 4'd0;
            end
            S_MUL: begin
                if (cnt_reg == 4'd8) begin
                    state_next = n_zero ? S_OUT : S_NORM;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_NORM: begin
                if (nstat.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == FN_FACE)) begin
            corner_reg[0] <= s_tdata[11:0];
            corner_reg[1] <= s_tdata[23:12];
            corner_reg[2] <= s_tdata[35:24];
        end
        if (state_reg == S_READ && cnt_reg != 4'd0) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[2'(cnt_reg - 4'd1)][i] <= mem_rdata[i*CW +: CW];
            end
        end
        if (state_reg == S_EDGE) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i]   <= (CW+1)'(p_reg[1][i]) - (CW+1)'(p_reg[0][i]);
                e2_reg[i]   <= (CW+1)'(p_reg[2][i]) - (CW+1)'(p_reg[0][i]);
                sneg_reg[i] <= sum_s[i][CW+1];
                x_reg[i]    <= (CW+1)'(sum_s[i][CW+1] ? -sum_s[i] : sum_s[i]) + 1'b1;
            end
        end
        if (state_reg == S_MUL) begin
            case (cnt_reg)
                4'd0, 4'd2, 4'd4: t_reg <= mul_p[NW-1:0];
                4'd1: n_reg[0] <= t_reg - mul_p[NW-1:0];
                4'd3: n_reg[1] <= t_reg - mul_p[NW-1:0];
                4'd5: n_reg[2] <= t_reg - mul_p[NW-1:0];
                4'd6: mid_reg[0] <= sneg_reg[0] ? -$signed({1'b0, d3_q}) : $signed({1'b0, d3_q});
                4'd7: mid_reg[1] <= sneg_reg[1] ? -$signed({1'b0, d3_q}) : $signed({1'b0, d3_q});
                default: begin
                    mid_reg[2] <= sneg_reg[2] ? -$signed({1'b0, d3_q}) : $signed({1'b0, d3_q});
                    deg_reg    <= n_zero;
                end
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= {FIELD_BITS'(mid_reg[2]), FIELD_BITS'(mid_reg[1]),
                            FIELD_BITS'(mid_reg[0]),
                            deg_reg ? '0 : q_z, deg_reg ? '0 : q_y, deg_reg ? '0 : q_x};
            m_tuser_reg <= deg_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a waiting word");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[47:0] == 48'd0))
        else $error("degenerate face with nonzero normal");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= NORM_ONE
                      && $signed(m_tdata[15:0]) >= -NORM_ONE
                      && $signed(m_tdata[31:16]) <= NORM_ONE
                      && $signed(m_tdata[31:16]) >= -NORM_ONE
                      && $signed(m_tdata[47:32]) <= NORM_ONE
                      && $signed(m_tdata[47:32]) >= -NORM_ONE))
        else $error("normal component out of range");

    a_norm_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        nstat.busy |-> (state_reg == S_NORM || state_reg == S_MUL))
        else $error("normalizer busy outside a face");

endmodule
